@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HTM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define HTM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define HTM_ASSERT(lbl, clk, rstn, prop)
`define HTM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ rtl/htm_pkg.sv @@
// ---------------------------------------------------------------------------
// Hop table mesh router package
// Sizes, codes and item types shared by the router and its table cells.
// ---------------------------------------------------------------------------
`default_nettype none

package htm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0] HOPS_UNKNOWN = 8'hFF;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MSG  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ACT_DROP    = 3'd0,
    ACT_DELIVER = 3'd1,
    ACT_FORWARD = 3'd2,
    ACT_ADVERT  = 3'd3,
    ACT_ADDED   = 3'd4,
    ACT_FULL    = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    REG_OWN_ID   = 2'd0,
    REG_WILDCARD = 2'd1,
    REG_HOP_TYPE = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] msg_type;
    logic [7:0] dest_id;
    logic [7:0] hop_value;
    logic [7:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] out_id;
    logic [7:0] out_hops;
    logic [7:0] out_radius;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] hops;
  } entry_t;

  typedef struct packed {
    logic       rotate;
    logic       advertise;
    logic       insert;
    logic [7:0] key;
    logic [7:0] hop_value;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic tail;
    logic sel;
  } cell_pos_t;

  typedef struct packed {
    logic       present;
    logic       closer;
    logic [7:0] hops;
  } cell_hit_t;

endpackage

`default_nettype wire

@@ rtl/htm_cell.sv @@
// ---------------------------------------------------------------------------
// Hop table cell
// One table entry: lookup chain stage, in-place hop update, insert, rotate.
// ---------------------------------------------------------------------------
`default_nettype none

module htm_cell import htm_pkg::*; (
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  cell_pos_t  pos_i,
  input  entry_t     next_i,
  input  entry_t     head_i,
  input  cell_hit_t  hit_i,
  output cell_hit_t  hit_o,
  output entry_t     entry_o
);

  entry_t     entry_q;
  entry_t     entry_d;
  logic       key_match;
  logic [7:0] hop_inc;

  assign key_match = pos_i.valid && (entry_q.id == ctrl_i.key);
  assign hop_inc   = ctrl_i.hop_value + 8'd1;

  always_comb begin
    hit_o         = hit_i;
    hit_o.present = hit_i.present || key_match;
    if (!hit_i.closer && key_match && (entry_q.hops < ctrl_i.hop_value)) begin
      hit_o.closer = 1'b1;
      hit_o.hops   = entry_q.hops;
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rotate) begin
      entry_d = pos_i.tail ? head_i : next_i;
    end else if (ctrl_i.insert && pos_i.sel) begin
      entry_d.id   = ctrl_i.key;
      entry_d.hops = HOPS_UNKNOWN;
    end else if (ctrl_i.advertise && key_match && (ctrl_i.hop_value != HOPS_UNKNOWN) &&
                 (hop_inc < entry_q.hops)) begin
      entry_d.hops = hop_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/hop_table_mesh_router.sv @@
// An add item, or a message that is not a hop advertisement, gives one result,
// registered in out_q; a new item is taken only once the block is back in idle,
// so in_stall_o stays high while an item is in hand.
// A tick gives 1 + n results, one per cycle unless the output stalls, as the cell row rotates by one entry.
// Reset clears the entry count, control state and registers; no clearing pass.
// ---------------------------------------------------------------------------
// Hop table mesh router
// Distance-vector hop table held in a row of cells, with APB register port.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hop_table_mesh_router import htm_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_item_t  out_item_o,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic [7:0] own_id_q, wildcard_q, hop_type_q;
  logic       cfg_wr;

  state_e     state_q, state_d;
  in_item_t   in_q;
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_load, out_free;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] tick_k_q, tick_k_d;

  cell_ctrl_t ctrl;
  cell_hit_t  hit [TABLE_DEPTH+1];
  entry_t     entries [TABLE_DEPTH];

  logic is_adv, is_tick_more, table_full, tick_done;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q   <= 8'd0;
      wildcard_q <= 8'hFF;
      hop_type_q <= 8'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OWN_ID:   own_id_q   <= pwdata[7:0];
        REG_WILDCARD: wildcard_q <= pwdata[7:0];
        REG_HOP_TYPE: hop_type_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OWN_ID:   prdata = {24'd0, own_id_q};
      REG_WILDCARD: prdata = {24'd0, wildcard_q};
      REG_HOP_TYPE: prdata = {24'd0, hop_type_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Cell row
  assign hit[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cell_pos_t pos;
    entry_t    nxt;
    assign pos.valid = CNT_W'(g) < count_q;
    assign pos.tail  = CNT_W'(g + 1) == count_q;
    assign pos.sel   = CNT_W'(g) == count_q;
    if (g == TABLE_DEPTH - 1) begin : g_end
      assign nxt = entries[g];
    end else begin : g_mid
      assign nxt = entries[g + 1];
    end
    htm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .next_i  (nxt),
      .head_i  (entries[0]),
      .hit_i   (hit[g]),
      .hit_o   (hit[g + 1]),
      .entry_o (entries[g])
    );
  end

  // Control
  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = state_q != ST_IDLE;
  assign is_adv       = (in_q.operation == OP_MSG) && (in_q.msg_type == hop_type_q);
  assign is_tick_more = (in_q.operation == OP_TICK) && (count_q != '0);
  assign table_full   = count_q == CNT_W'(TABLE_DEPTH);
  assign tick_done    = (tick_k_q + CNT_W'(1)) == count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_adv || (in_q.operation != OP_ADD && in_q.operation != OP_MSG &&
                       in_q.operation != OP_TICK)) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          state_d = is_tick_more ? ST_TICK : ST_IDLE;
        end
      end
      ST_TICK: begin
        if (out_free && tick_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load       = 1'b0;
    out_d          = out_q;
    count_d        = count_q;
    tick_k_d       = tick_k_q;
    ctrl           = '0;
    ctrl.key       = in_q.dest_id;
    ctrl.hop_value = in_q.hop_value;
    unique case (state_q)
      ST_IDLE: ;
      ST_EXEC: begin
        out_d.out_id     = in_q.dest_id;
        out_d.out_hops   = in_q.hop_value;
        out_d.out_radius = in_q.radius;
        out_d.last       = 1'b1;
        case (in_q.operation)
          OP_ADD: begin
            out_load         = out_free;
            out_d.out_hops   = 8'd0;
            out_d.out_radius = 8'd0;
            out_d.action     = ACT_ADDED;
            if (!hit[TABLE_DEPTH].present) begin
              if (table_full) begin
                out_d.action = ACT_FULL;
              end else begin
                ctrl.insert = out_free;
                if (out_free) count_d = count_q + CNT_W'(1);
              end
            end
          end
          OP_MSG: begin
            if (is_adv) begin
              ctrl.advertise = 1'b1;
            end else begin
              out_load = out_free;
              if (in_q.dest_id == own_id_q || in_q.dest_id == wildcard_q) begin
                out_d.action = ACT_DELIVER;
              end else if (hit[TABLE_DEPTH].closer) begin
                out_d.action   = ACT_FORWARD;
                out_d.out_hops = (hit[TABLE_DEPTH].hops != 8'd0) ?
                                 hit[TABLE_DEPTH].hops - 8'd1 : 8'd0;
              end else if (in_q.radius == 8'd0) begin
                out_d.action = ACT_DROP;
              end else begin
                out_d.action     = ACT_FORWARD;
                out_d.out_radius = in_q.radius - 8'd1;
              end
            end
          end
          OP_TICK: begin
            out_load         = out_free;
            out_d.action     = ACT_ADVERT;
            out_d.out_id     = own_id_q;
            out_d.out_hops   = 8'd0;
            out_d.out_radius = 8'd0;
            out_d.last       = count_q == '0;
            tick_k_d         = '0;
          end
          default: ;
        endcase
      end
      ST_TICK: begin
        out_d.action     = ACT_ADVERT;
        out_d.out_id     = entries[0].id;
        out_d.out_hops   = entries[0].hops;
        out_d.out_radius = 8'd0;
        out_d.last       = tick_done;
        if (out_free) begin
          out_load    = 1'b1;
          ctrl.rotate = 1'b1;
          tick_k_d    = tick_k_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      tick_k_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      tick_k_q <= tick_k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_item_i;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `HTM_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(TABLE_DEPTH))
  `HTM_ASSERT(a_tick_in_range, clk_i, rst_ni, (state_q == ST_TICK) |-> (tick_k_q < count_q))
  `HTM_ASSERT(a_last_ends_item, clk_i, rst_ni, (out_load && out_d.last) |=> (state_q == ST_IDLE))
  `HTM_ASSERT(a_count_grows_by_one, clk_i, rst_ni, !$stable(count_q) |-> (count_q == ($past(count_q) + CNT_W'(1))))

endmodule

`default_nettype wire

@@ dv/hop_table_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hop table router checker
// Watches the register port and both item channels, keeps its own copy of
// the routing table and flags every result that differs from the prediction.
// ---------------------------------------------------------------------------
module hop_table_checker import htm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [7:0]  own_id_q;
  logic [7:0]  wildcard_q;
  logic [7:0]  hop_type_q;
  logic [7:0]  route_ids[TABLE_DEPTH];
  logic [7:0]  route_hops[TABLE_DEPTH];
  int          route_count;
  int          fails;
  out_item_t   expected_q[$];

  function automatic out_item_t route_result(input logic [2:0] act, input logic [7:0] id,
                                             input logic [7:0] hops, input logic [7:0] rad,
                                             input logic fin);
    out_item_t r;
    r.action     = act;
    r.out_id     = id;
    r.out_hops   = hops;
    r.out_radius = rad;
    r.last       = fin;
    return r;
  endfunction

  task automatic route_item(input in_item_t it);
    bit         hit;
    logic [8:0] bumped;
    case (it.operation)
      OP_ADD: begin
        hit = 1'b0;
        for (int i = 0; i < route_count; i++)
          if (route_ids[i] == it.dest_id) hit = 1'b1;
        if (!hit && route_count < TABLE_DEPTH) begin
          route_ids[route_count]  = it.dest_id;
          route_hops[route_count] = HOPS_UNKNOWN;
          route_count++;
          hit = 1'b1;
        end
        expected_q.push_back(route_result(hit ? ACT_ADDED : ACT_FULL, it.dest_id,
                                          8'd0, 8'd0, 1'b1));
      end
      OP_MSG: begin
        if (it.msg_type == hop_type_q) begin
          // hop advertisement: silent table update
          if (it.hop_value != HOPS_UNKNOWN) begin
            bumped = {1'b0, it.hop_value} + 9'd1;
            for (int i = 0; i < route_count; i++)
              if (route_ids[i] == it.dest_id && bumped < {1'b0, route_hops[i]})
                route_hops[i] = bumped[7:0];
          end
        end else if (it.dest_id == own_id_q || it.dest_id == wildcard_q) begin
          expected_q.push_back(route_result(ACT_DELIVER, it.dest_id, it.hop_value,
                                            it.radius, 1'b1));
        end else begin
          hit = 1'b0;
          for (int i = 0; i < route_count; i++) begin
            if (!hit && route_ids[i] == it.dest_id && route_hops[i] < it.hop_value) begin
              hit = 1'b1;
              expected_q.push_back(route_result(ACT_FORWARD, it.dest_id,
                                                (route_hops[i] == 8'd0) ? 8'd0
                                                                        : route_hops[i] - 8'd1,
                                                it.radius, 1'b1));
            end
          end
          if (!hit) begin
            if (it.radius == 8'd0)
              expected_q.push_back(route_result(ACT_DROP, it.dest_id, it.hop_value,
                                                8'd0, 1'b1));
            else
              expected_q.push_back(route_result(ACT_FORWARD, it.dest_id, it.hop_value,
                                                it.radius - 8'd1, 1'b1));
          end
        end
      end
      OP_TICK: begin
        expected_q.push_back(route_result(ACT_ADVERT, own_id_q, 8'd0, 8'd0,
                                          route_count == 0));
        for (int i = 0; i < route_count; i++)
          expected_q.push_back(route_result(ACT_ADVERT, route_ids[i], route_hops[i], 8'd0,
                                            i + 1 == route_count));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    if (!rst_ni) begin
      own_id_q    = 8'd0;
      wildcard_q  = 8'd255;
      hop_type_q  = 8'd1;
      route_count = 0;
      fails       = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[3:2]))
          REG_OWN_ID:   own_id_q   = pwdata_i[7:0];
          REG_WILDCARD: wildcard_q = pwdata_i[7:0];
          REG_HOP_TYPE: hop_type_q = pwdata_i[7:0];
          default: ;
        endcase
      end
      // results first: an item accepted at this edge cannot have produced one yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: action %0d id %0d hops %0d radius %0d",
                 out_item_i.action, out_item_i.out_id, out_item_i.out_hops,
                 out_item_i.out_radius);
          fails++;
        end else begin
          exp = expected_q.pop_front();
          if (exp.action !== out_item_i.action) begin
            $error("action mismatch: expected %0d, got %0d", exp.action, out_item_i.action);
            fails++;
          end
          if (exp.out_id !== out_item_i.out_id) begin
            $error("out_id mismatch: expected %0d, got %0d", exp.out_id, out_item_i.out_id);
            fails++;
          end
          if (exp.out_hops !== out_item_i.out_hops) begin
            $error("out_hops mismatch: expected %0d, got %0d", exp.out_hops,
                   out_item_i.out_hops);
            fails++;
          end
          if (exp.out_radius !== out_item_i.out_radius) begin
            $error("out_radius mismatch: expected %0d, got %0d", exp.out_radius,
                   out_item_i.out_radius);
            fails++;
          end
          if (exp.last !== out_item_i.last) begin
            $error("last mismatch: expected %0d, got %0d", exp.last, out_item_i.last);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) route_item(in_item_i);
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hop table router testbench
// Directed and random route items over several register settings, with
// random gaps and back-pressure; results are checked by hop_table_checker.
// ---------------------------------------------------------------------------
module tb_top;
  import htm_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         PHASES       = 6;
  localparam int         PHASE_ITEMS  = 55;
  localparam int         DRAIN_CYCLES = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending_results;
  int          cycles = 0;
  int          idle_pct = 37;
  int          stall_pct = 37;
  logic [7:0]  cfg_own;
  logic [7:0]  cfg_wild;
  logic [7:0]  cfg_hop;
  logic [7:0]  id_pool[24];

  hop_table_mesh_router dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  hop_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic in_item_t pack_item(input logic [1:0] op, input logic [7:0] ty,
                                         input logic [7:0] dest, input logic [7:0] hv,
                                         input logic [7:0] rad);
    in_item_t it;
    it.operation = op;
    it.msg_type  = ty;
    it.dest_id   = dest;
    it.hop_value = hv;
    it.radius    = rad;
    return it;
  endfunction

  // called at a rising edge, returns at the edge where the item is taken
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input reg_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apply_config(input logic [7:0] own, input logic [7:0] wild,
                              input logic [7:0] hop);
    cfg_own  = own;
    cfg_wild = wild;
    cfg_hop  = hop;
    write_reg(REG_OWN_ID, own);
    write_reg(REG_WILDCARD, wild);
    write_reg(REG_HOP_TYPE, hop);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // advertisements give no result, so keep waiting for DRAIN_CYCLES after the queue empties
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    int       sent;
    int       pick;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(255));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) wait_drained();
      case (phase)
        0: apply_config(8'h12, 8'hFF, 8'h01);
        1: apply_config(8'h00, 8'h00, 8'h00);
        2: apply_config(8'hFF, 8'hFF, 8'hFF);
        3: apply_config(8'hAA, 8'h55, 8'($urandom_range(255)));
        default: apply_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
      endcase
      idle_pct  = (phase == 4) ? 0 : 37;
      stall_pct = (phase == 4) ? 0 : 37;

      if (phase == 0) begin
        send_item(pack_item(OP_TICK,   8'h00, 8'h00, 8'h00, 8'h00));
        send_item(pack_item(OP_ADD,    8'hFF, 8'h00, 8'hFF, 8'hFF));
        send_item(pack_item(OP_ADD,    8'h00, 8'hFF, 8'h00, 8'h00));
        send_item(pack_item(OP_ADD,    8'h00, 8'h00, 8'h00, 8'h00));
        send_item(pack_item(OP_ADD,    8'h00, 8'h37, 8'h00, 8'h00));
        // advertisements: none, saturating, lowering, not lower, lowest
        send_item(pack_item(OP_MSG,    cfg_hop, 8'h37, 8'hFF, 8'h00));
        send_item(pack_item(OP_MSG,    cfg_hop, 8'h37, 8'hFE, 8'h00));
        send_item(pack_item(OP_MSG,    cfg_hop, 8'h37, 8'h03, 8'h00));
        send_item(pack_item(OP_MSG,    cfg_hop, 8'h37, 8'h07, 8'h00));
        send_item(pack_item(OP_MSG,    cfg_hop, 8'h00, 8'h00, 8'hFF));
        send_item(pack_item(OP_MSG,    8'hFE, cfg_own, 8'h09, 8'h05));
        send_item(pack_item(OP_MSG,    8'hFF, cfg_wild, 8'h00, 8'h00));
        send_item(pack_item(OP_MSG,    8'h00, 8'h37, 8'h09, 8'h03));
        send_item(pack_item(OP_MSG,    8'h00, 8'h37, 8'h04, 8'h03));
        send_item(pack_item(OP_MSG,    8'h80, 8'h00, 8'hFF, 8'h00));
        send_item(pack_item(OP_MSG,    8'h02, 8'h55, 8'hC8, 8'h00));
        send_item(pack_item(OP_MSG,    8'h02, 8'h55, 8'h00, 8'hFF));
        send_item(pack_item(OP_MSG,    8'h7F, 8'h37, 8'hFF, 8'h01));
        send_item(pack_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(pack_item(OP_TICK,   8'hFF, 8'hFF, 8'hFF, 8'hFF));
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        it.msg_type  = 8'($urandom_range(255));
        it.hop_value = 8'($urandom_range(1) ? $urandom_range(20) : $urandom_range(255));
        pick = $urandom_range(9);
        it.radius    = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : 8'($urandom_range(255));
        pick = $urandom_range(9);
        it.dest_id   = (pick < 7) ? id_pool[$urandom_range(23)] :
                       (pick == 7) ? cfg_own : (pick == 8) ? cfg_wild :
                       8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20) begin
          it.operation = OP_ADD;
        end else if (pick < 45) begin
          it.operation = OP_MSG;
          it.msg_type  = cfg_hop;
          it.hop_value = 8'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                     : $urandom_range(15));
        end else if (pick < 85) begin
          it.operation = OP_MSG;
        end else if (pick < 93) begin
          it.operation = OP_TICK;
        end else begin
          it.operation = OP_UNUSED;
        end
        send_item(it);
        if (it.operation != OP_UNUSED) sent++;
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
